// ----- src/jse_pkg.sv -----
package jse_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
  } out_word_t;

  // position within the escape sequence, up to six bytes
  typedef logic [2:0] pos_t;

  localparam logic       FUNC_DATA  = 1'b0;
  localparam logic       FUNC_END   = 1'b1;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_N       = 8'h6e;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_MINUS = 8'h57;  // 'a' - 10
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  localparam pos_t LEN_ONE   = 3'd1;
  localparam pos_t LEN_SHORT = 3'd2;
  localparam pos_t LEN_UNI   = 3'd6;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] ext;
    begin
      ext = {4'd0, v};
      hex_digit = (v < 4'd10) ? (CH_ZERO + ext) : (CH_A_MINUS + ext);
    end
  endfunction

  // letter of a two-byte escape, zero if there is none
  function automatic logic [7:0] short_escape(input logic [7:0] c);
    begin
      case (c)
        8'd8:      short_escape = CH_B;
        8'd9:      short_escape = CH_T;
        8'd10:     short_escape = CH_N;
        8'd12:     short_escape = CH_F;
        8'd13:     short_escape = CH_R;
        CH_QUOTE:  short_escape = CH_QUOTE;
        CH_BSLASH: short_escape = CH_BSLASH;
        default:   short_escape = 8'd0;
      endcase
    end
  endfunction

endpackage

// ----- src/jse_encode.sv -----
module jse_encode (
  input  jse_pkg::in_word_t  item,
  input  jse_pkg::pos_t      pos,
  output jse_pkg::out_word_t word
);

  logic [7:0]   esc;
  jse_pkg::pos_t len;
  logic [7:0]   ch;
  logic         done;

  always_comb begin
    esc  = jse_pkg::short_escape(item.in_byte);
    done = 1'b0;
    ch   = item.in_byte;
    if (item.func == jse_pkg::FUNC_END) begin
      len  = jse_pkg::LEN_ONE;
      ch   = jse_pkg::CH_QUOTE;
      done = 1'b1;
    end else if (esc != 8'd0) begin
      len = jse_pkg::LEN_SHORT;
      ch  = (pos == 3'd0) ? jse_pkg::CH_BSLASH : esc;
    end else if (item.in_byte >= jse_pkg::CTRL_LIMIT) begin
      len = jse_pkg::LEN_ONE;
      ch  = item.in_byte;
    end else begin
      // backslash u 0 0 hi lo
      len = jse_pkg::LEN_UNI;
      case (pos)
        3'd0:    ch = jse_pkg::CH_BSLASH;
        3'd1:    ch = jse_pkg::CH_U;
        3'd2:    ch = jse_pkg::CH_ZERO;
        3'd3:    ch = jse_pkg::CH_ZERO;
        3'd4:    ch = jse_pkg::hex_digit(item.in_byte[7:4]);
        default: ch = jse_pkg::hex_digit(item.in_byte[3:0]);
      endcase
    end
    word.out_byte    = ch;
    word.last_of_run = (pos == (len - 3'd1));
    word.string_done = done;
  end

endmodule

// ----- src/json_string_escaper_top.sv -----
// an accepted word is registered in a_word_r and its first escaped byte in o_word_r;
// one output byte per cycle while out_stall is low; plain bytes and end marks take
// one byte, two-byte escapes two, \u00XX escapes six, set by the single output port
// reset: synchronous active-low rst_n empties the input and output registers
module json_string_escaper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jse_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jse_pkg::out_word_t  out_data
);

  logic               a_valid_r, a_valid_nxt;
  jse_pkg::in_word_t  a_word_r, a_word_nxt;
  jse_pkg::pos_t      a_pos_r, a_pos_nxt;
  logic               o_valid_r, o_valid_nxt;
  jse_pkg::out_word_t o_word_r, o_word_nxt;

  jse_pkg::out_word_t enc_word;
  logic               advance;
  logic               a_done;
  logic               accept;

  jse_encode u_encode (
    .item (a_word_r),
    .pos  (a_pos_r),
    .word (enc_word)
  );

  always_comb begin
    advance  = a_valid_r && (!o_valid_r || !out_stall);
    a_done   = advance && enc_word.last_of_run;
    in_stall = a_valid_r && !a_done;
    accept   = in_valid && !in_stall;

    a_valid_nxt = a_valid_r;
    a_word_nxt  = a_word_r;
    a_pos_nxt   = a_pos_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
      a_word_nxt  = in_data;
      a_pos_nxt   = 3'd0;
    end else if (a_done) begin
      a_valid_nxt = 1'b0;
    end else if (advance) begin
      a_pos_nxt = a_pos_r + 3'd1;
    end

    o_valid_nxt = o_valid_r;
    o_word_nxt  = o_word_r;
    if (advance) begin
      o_valid_nxt = 1'b1;
      o_word_nxt  = enc_word;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_pos_r   <= 3'd0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      a_pos_r   <= a_pos_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    a_word_r <= a_word_nxt;
    o_word_r <= o_word_nxt;
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_word_r;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_WORDS = 77;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  jse_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  jse_pkg::out_word_t out_data;

  jse_pkg::in_word_t  pending_q[$];
  jse_pkg::out_word_t escaped_q[$];
  int        words_total = 0;
  int        words_taken = 0;
  int        idle_cycles = 0;
  int        fail_count  = 0;

  json_string_escaper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // three idling phases by progress through the stimulus
  function automatic int sender_idle_pct(int taken);
    if (taken < words_total / 3) return 14;
    if (taken < 2 * words_total / 3) return 49;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(int taken);
    if (taken < words_total / 3) return 49;
    if (taken < 2 * words_total / 3) return 14;
    return 0;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? jse_pkg::CH_ZERO + {4'd0, nib}
                         : jse_pkg::CH_A_MINUS + {4'd0, nib};
  endfunction

  task automatic push_escaped(logic [7:0] b, logic last, logic done);
    jse_pkg::out_word_t r;
    r.out_byte    = b;
    r.last_of_run = last;
    r.string_done = done;
    escaped_q.push_back(r);
  endtask

  // expected escaped text for one accepted word
  task automatic predict_escape(jse_pkg::in_word_t w);
    logic [7:0] letter;
    if (w.func == jse_pkg::FUNC_END) begin
      push_escaped(jse_pkg::CH_QUOTE, 1'b1, 1'b1);
      return;
    end
    case (w.in_byte)
      8'd8:               letter = jse_pkg::CH_B;
      8'd9:               letter = jse_pkg::CH_T;
      8'd10:              letter = jse_pkg::CH_N;
      8'd12:              letter = jse_pkg::CH_F;
      8'd13:              letter = jse_pkg::CH_R;
      jse_pkg::CH_QUOTE:  letter = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BSLASH: letter = jse_pkg::CH_BSLASH;
      default:            letter = 8'd0;
    endcase
    if (letter != 8'd0) begin
      push_escaped(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_escaped(letter, 1'b1, 1'b0);
    end else if (w.in_byte >= jse_pkg::CTRL_LIMIT) begin
      push_escaped(w.in_byte, 1'b1, 1'b0);
    end else begin
      push_escaped(jse_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_escaped(jse_pkg::CH_U, 1'b0, 1'b0);
      push_escaped(jse_pkg::CH_ZERO, 1'b0, 1'b0);
      push_escaped(jse_pkg::CH_ZERO, 1'b0, 1'b0);
      push_escaped(hex_char(w.in_byte[7:4]), 1'b0, 1'b0);
      push_escaped(hex_char(w.in_byte[3:0]), 1'b1, 1'b0);
    end
  endtask

  task automatic queue_word(logic func, logic [7:0] b);
    jse_pkg::in_word_t w;
    w.func    = func;
    w.in_byte = b;
    pending_q.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_escape(in_data);
        words_taken <= words_taken + 1;
      end
      if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct(words_taken)) begin
        in_valid <= 1'b1;
        in_data  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct(words_taken));
    end
  end

  // monitor
  always @(posedge clk) begin
    jse_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        $error("unexpected word: out_byte %h", out_data.out_byte);
        fail_count++;
      end else begin
        want = escaped_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
          fail_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_data.last_of_run);
          fail_count++;
        end
        if (out_data.string_done !== want.string_done) begin
          $error("string_done: expected %b, got %b", want.string_done, out_data.string_done);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("json_string_escaper_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    jse_pkg::in_word_t w;
    // control bytes, short escapes, printable edges and end marks
    queue_word(jse_pkg::FUNC_DATA, 8'h00);
    queue_word(jse_pkg::FUNC_DATA, 8'h01);
    queue_word(jse_pkg::FUNC_DATA, 8'h08);
    queue_word(jse_pkg::FUNC_DATA, 8'h09);
    queue_word(jse_pkg::FUNC_DATA, 8'h0a);
    queue_word(jse_pkg::FUNC_DATA, 8'h0b);
    queue_word(jse_pkg::FUNC_DATA, 8'h0c);
    queue_word(jse_pkg::FUNC_DATA, 8'h0d);
    queue_word(jse_pkg::FUNC_DATA, 8'h0f);
    queue_word(jse_pkg::FUNC_DATA, 8'h10);
    queue_word(jse_pkg::FUNC_DATA, 8'h1f);
    queue_word(jse_pkg::FUNC_DATA, jse_pkg::CH_QUOTE);
    queue_word(jse_pkg::FUNC_DATA, jse_pkg::CH_BSLASH);
    queue_word(jse_pkg::FUNC_DATA, 8'h20);
    queue_word(jse_pkg::FUNC_DATA, 8'h21);
    queue_word(jse_pkg::FUNC_DATA, 8'h5b);
    queue_word(jse_pkg::FUNC_DATA, 8'h5d);
    queue_word(jse_pkg::FUNC_DATA, 8'h7f);
    queue_word(jse_pkg::FUNC_DATA, 8'h80);
    queue_word(jse_pkg::FUNC_DATA, 8'hff);
    queue_word(jse_pkg::FUNC_END, 8'h00);
    queue_word(jse_pkg::FUNC_END, 8'hff);
    queue_word(jse_pkg::FUNC_END, jse_pkg::CH_QUOTE);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w.func    = jse_pkg::FUNC_DATA;
      w.in_byte = 8'($urandom);
      case ($urandom_range(9))
        0, 1, 2, 3: w.in_byte = 8'($urandom_range(255, 32));
        4, 5: begin
          case ($urandom_range(6))
            0: w.in_byte = 8'd8;
            1: w.in_byte = 8'd9;
            2: w.in_byte = 8'd10;
            3: w.in_byte = 8'd12;
            4: w.in_byte = 8'd13;
            5: w.in_byte = jse_pkg::CH_QUOTE;
            default: w.in_byte = jse_pkg::CH_BSLASH;
          endcase
        end
        6, 7: w.in_byte = 8'($urandom_range(31, 0));
        8: ;
        default: w.func = jse_pkg::FUNC_END;
      endcase
      pending_q.push_back(w);
    end
    words_total = pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_taken == words_total);
    while (escaped_q.size() != 0) @(posedge clk);
    // any stray word after the last expected one is caught by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("json_string_escaper_top: match");
    end else begin
      $display("json_string_escaper_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- json_string_escaper_top.f -----
src/jse_pkg.sv
src/jse_encode.sv
src/json_string_escaper_top.sv
verif/tb.sv
